/* src/sorted_name_table_lookup_top_defines.svh */
// Assertion macros used by the sorted name table lookup controller.
`ifndef SORTED_NAME_TABLE_LOOKUP_TOP_DEFINES_SVH
`define SORTED_NAME_TABLE_LOOKUP_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SNTL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SNTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/sntl_pkg.sv */
// Shared types and constants of the sorted name table lookup.
package sntl_pkg;

  // Fixed widths of the configuration registers and the words.
  localparam int CW = 11;
  localparam int IW = 10;
  localparam int KW = 32;
  localparam int RW = 1;

  // Configuration register indexes.
  localparam logic [RW-1:0] REG_ENTRY_COUNT   = 1'b0;
  localparam logic [RW-1:0] REG_SPECIAL_COUNT = 1'b1;

  // Input word modes.
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_WRITE  = 1'b1;

  // Source of the table read address.
  typedef enum logic [1:0] {
    SEL_CACHE = 2'd0,
    SEL_SCAN  = 2'd1,
    SEL_MID   = 2'd2
  } sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic wr;
    logic rd;
    sel_t rd_sel;
    logic step_bin;
    logic emit_hit;
    logic emit_miss;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cache_ok;
    logic scan_more;
    logic bin_more;
    logic eq;
    logic bin_cont;
  } stat_t;

endpackage

/* src/sntl_ctrl.sv */
// Controller state machine that sequences the cache, scan and binary probes.
`include "sorted_name_table_lookup_top_defines.svh"

module sntl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          mode,
  output logic          busy,
  output sntl_pkg::cmd_t cmd,
  input  sntl_pkg::stat_t stat
);
  import sntl_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_CHECK    = 7'b0000010,
    S_CACHE_RD = 7'b0000100,
    S_CACHE_CMP = 7'b0001000,
    S_SCAN_RD  = 7'b0010000,
    S_SCAN_CMP = 7'b0100000,
    S_BIN_RD   = 7'b1000000
  } state_t;

  // The binary compare shares the read state code space through a flag.
  state_t state_r, state_nxt;
  logic   bin_cmp_r, bin_cmp_nxt;
  state_t phase_nxt;
  logic   miss_now;

  // Next search phase once the current one has nothing left.
  always_comb begin
    miss_now = 1'b0;
    if (stat.scan_more) begin
      phase_nxt = S_SCAN_RD;
    end else if (stat.bin_more) begin
      phase_nxt = S_BIN_RD;
    end else begin
      phase_nxt = S_IDLE;
      miss_now  = 1'b1;
    end
  end

  // State transitions and commands.
  always_comb begin
    state_nxt   = state_r;
    bin_cmp_nxt = 1'b0;
    cmd         = '0;
    cmd.rd_sel  = SEL_CACHE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (mode == MODE_WRITE) begin
            cmd.wr = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (stat.cache_ok) begin
          state_nxt = S_CACHE_RD;
        end else begin
          state_nxt     = phase_nxt;
          cmd.emit_miss = miss_now;
        end
      end
      S_CACHE_RD: begin
        cmd.rd     = 1'b1;
        cmd.rd_sel = SEL_CACHE;
        state_nxt  = S_CACHE_CMP;
      end
      S_CACHE_CMP: begin
        if (stat.eq) begin
          cmd.emit_hit = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt     = phase_nxt;
          cmd.emit_miss = miss_now;
        end
      end
      S_SCAN_RD: begin
        cmd.rd     = 1'b1;
        cmd.rd_sel = SEL_SCAN;
        state_nxt  = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (stat.eq) begin
          cmd.emit_hit = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt     = phase_nxt;
          cmd.emit_miss = miss_now;
        end
      end
      S_BIN_RD: begin
        // Without the flag the state issues the read; with the flag set it compares.
        if (!bin_cmp_r) begin
          cmd.rd      = 1'b1;
          cmd.rd_sel  = SEL_MID;
          bin_cmp_nxt = 1'b1;
        end else if (stat.eq) begin
          cmd.emit_hit = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.step_bin = 1'b1;
          if (!stat.bin_cont) begin
            cmd.emit_miss = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      bin_cmp_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      bin_cmp_r <= bin_cmp_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  `SNTL_ASSERT_SAME(a_emit_excl, clk, rst_n, cmd.emit_hit, !cmd.emit_miss, "hit and miss together")
  `SNTL_ASSERT_NEXT(a_emit_idle, clk, rst_n, cmd.emit_hit || cmd.emit_miss, !busy, "busy after result")
  `SNTL_ASSERT_NEXT(a_lookup_busy, clk, rst_n, start && !busy && (mode == MODE_LOOKUP), busy, "lookup not started")
  `SNTL_ASSERT_SAME(a_write_idle, clk, rst_n, cmd.wr, !busy && !cmd.rd, "table write while searching")

endmodule

/* src/sntl_datapath.sv */
// Datapath: key table memory, configuration registers, search pointers and result word.
module sntl_datapath #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [sntl_pkg::RW-1:0]    cfg_index,
  input  logic [sntl_pkg::CW-1:0]    cfg_wdata,
  input  logic [sntl_pkg::IW-1:0]    in_entry_index,
  input  logic [sntl_pkg::KW-1:0]    in_name_key,
  input  sntl_pkg::cmd_t             cmd,
  output sntl_pkg::stat_t            stat,
  output logic                       out_strobe,
  output logic [sntl_pkg::IW-1:0]    out_match_index,
  output logic                       out_found
);
  import sntl_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [KW-1:0] mem [TABLE_DEPTH];
  logic [KW-1:0] rd_data_r;

  logic [CW-1:0] entry_count_r, special_count_r;
  logic [KW-1:0] key_r;
  logic [CW-1:0] scan_i_r, lo_r, hi1_r, probe_r, cached_r;
  logic          out_strobe_r, out_found_r;
  logic [IW-1:0] out_match_index_r;

  logic [CW-1:0] count, scan_end, mid, rd_idx, probe_inc;
  logic [CW:0]   mid_sum;
  logic          lt;

  // Effective entry count and end of the special scan.
  always_comb begin
    if (32'(entry_count_r) > TABLE_DEPTH) begin
      count = CW'(TABLE_DEPTH);
    end else begin
      count = entry_count_r;
    end
    scan_end = (special_count_r < count) ? special_count_r : count;
  end

  // Probe address selection; mid rounds down over the inclusive range.
  always_comb begin
    mid_sum   = {1'b0, lo_r} + {1'b0, hi1_r} - (CW+1)'(1);
    mid       = mid_sum[CW:1];
    probe_inc = probe_r + CW'(1);
    unique case (cmd.rd_sel)
      SEL_CACHE: rd_idx = cached_r;
      SEL_SCAN:  rd_idx = scan_i_r;
      SEL_MID:   rd_idx = mid;
      default:   rd_idx = cached_r;
    endcase
  end

  // Status toward the controller.
  always_comb begin
    lt             = (key_r < rd_data_r);
    stat.cache_ok  = (cached_r < count);
    stat.scan_more = (scan_i_r < scan_end);
    stat.bin_more  = (lo_r < hi1_r);
    stat.eq        = (rd_data_r == key_r);
    stat.bin_cont  = lt ? (lo_r < probe_r) : (probe_inc < hi1_r);
  end

  // Key table: one write port for loads, one registered read port for probes.
  always_ff @(posedge clk) begin
    if (cmd.wr && (32'(in_entry_index) < TABLE_DEPTH)) begin
      mem[AW'(in_entry_index)] <= in_name_key;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[AW'(rd_idx)];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r   <= '0;
      special_count_r <= CW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENTRY_COUNT:   entry_count_r   <= cfg_wdata;
        REG_SPECIAL_COUNT: special_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Cached probe survives across lookups.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cached_r <= '0;
    end else if (cmd.rd && (cmd.rd_sel != SEL_CACHE)) begin
      cached_r <= rd_idx;
    end
  end

  // Search pointers and key of the word in progress.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r    <= in_name_key;
      scan_i_r <= '0;
      lo_r     <= special_count_r;
      hi1_r    <= count;
    end else begin
      if (cmd.rd) begin
        probe_r <= rd_idx;
        if (cmd.rd_sel == SEL_SCAN) begin
          scan_i_r <= scan_i_r + CW'(1);
        end
      end
      if (cmd.step_bin) begin
        if (lt) begin
          hi1_r <= probe_r;
        end else begin
          lo_r <= probe_inc;
        end
      end
    end
  end

  // Result word, shown for one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit_hit || cmd.emit_miss;
    end
    out_found_r       <= cmd.emit_hit;
    out_match_index_r <= cmd.emit_hit ? IW'(probe_r) : '0;
  end

  assign out_strobe      = out_strobe_r;
  assign out_found       = out_found_r;
  assign out_match_index = out_match_index_r;

endmodule

/* src/sorted_name_table_lookup_top.sv */
// Lookup: from start to out_strobe the block compares P table entries, one at a time.
// P is the cached probe (0 or 1), up to min(special_count, entry_count) scan probes and
// up to log2(entry_count) + 1 binary probes, each a read and then a compare on one port.
// Busy drops with out_strobe, so a new word is taken only once a lookup has finished;
// a write word leaves busy low. The receiver cannot stall the block.
// Reset clears the controller, the cached probe and the counts (entry 0, special 1), not the table.
module sorted_name_table_lookup_top #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [sntl_pkg::RW-1:0] cfg_index,
  input  logic [sntl_pkg::CW-1:0] cfg_wdata,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_mode,
  input  logic [sntl_pkg::IW-1:0] in_entry_index,
  input  logic [sntl_pkg::KW-1:0] in_name_key,
  output logic                    out_strobe,
  output logic [sntl_pkg::IW-1:0] out_match_index,
  output logic                    out_found
);
  import sntl_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Search sequencer.
  sntl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mode  (in_mode),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  // Table, pointers and result word.
  sntl_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_entry_index  (in_entry_index),
    .in_name_key     (in_name_key),
    .cmd             (cmd),
    .stat            (stat),
    .out_strobe      (out_strobe),
    .out_match_index (out_match_index),
    .out_found       (out_found)
  );

endmodule
